/* rtl/dvru_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dvru_pkg;

  localparam int NODE_COUNT_DEF = 8;
  localparam int DIST_BITS_DEF  = 16;
  localparam int NODE_W         = 3;
  localparam int DIST_W         = 16;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_VECTOR = 1'b1;

  typedef struct packed {
    logic              func;
    logic [NODE_W-1:0] sender;
    logic [NODE_W-1:0] dest;
    logic [DIST_W-1:0] dist_req;
    logic [NODE_W-1:0] hop;
    logic              last;
  } dvru_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] out_dest;
    logic [DIST_W-1:0] out_dist;
    logic [NODE_W-1:0] out_hop;
    logic              entry_changed;
    logic              table_changed;
    logic              out_last;
  } dvru_out_t;

endpackage
`default_nettype wire

/* rtl/dvru_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module dvru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/dvru_relax.sv */
`timescale 1ns / 1ps
`default_nettype none
module dvru_relax #(
  parameter int DIST_BITS = dvru_pkg::DIST_BITS_DEF
) (
  input  dvru_pkg::dvru_in_t            item_i,
  input  wire logic [dvru_pkg::NODE_W-1:0] own_node_i,
  input  wire logic [DIST_BITS-1:0]      cost_i,
  input  wire logic                      dest_ok_i,
  input  wire logic [DIST_BITS-1:0]      old_dist_i,
  input  wire logic [dvru_pkg::NODE_W-1:0] old_hop_i,
  output logic      [DIST_BITS-1:0]      new_dist_o,
  output logic      [dvru_pkg::NODE_W-1:0] new_hop_o,
  output logic                           changed_o
);
  import dvru_pkg::*;

  localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};

  logic [DIST_BITS-1:0] dreq;
  logic [DIST_BITS:0]   sum_full;
  logic [DIST_BITS-1:0] sum;
  logic [DIST_BITS-1:0] mid_dist;

  assign dreq     = DIST_BITS'(item_i.dist_req);
  assign sum_full = {1'b0, dreq} + {1'b0, cost_i};

  // saturate below infinity; either operand unreachable gives unreachable
  always_comb begin
    if (dreq == INF || cost_i == INF) begin
      sum = INF;
    end else if (sum_full >= {1'b0, INF}) begin
      sum = INF - 1'b1;
    end else begin
      sum = sum_full[DIST_BITS-1:0];
    end
  end

  always_comb begin
    new_dist_o = old_dist_i;
    new_hop_o  = old_hop_i;
    mid_dist   = old_dist_i;
    if (dest_ok_i) begin
      if (item_i.func == FUNC_LOAD) begin
        new_dist_o = dreq;
        new_hop_o  = item_i.hop;
      end else if (item_i.dest != own_node_i) begin
        // route through the sender follows whatever it now advertises
        if (old_hop_i == item_i.sender) begin
          mid_dist = sum;
        end
        new_dist_o = mid_dist;
        if (dreq != INF && sum != INF && sum < mid_dist) begin
          new_dist_o = sum;
          new_hop_o  = item_i.sender;
        end
      end
    end
  end

  assign changed_o = dest_ok_i && ((new_dist_o != old_dist_i) || (new_hop_o != old_hop_i));

endmodule
`default_nettype wire

/* rtl/distance_vector_route_update.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Handshake              | Payload
// ----------+------------------------+------------------------------
// item in   | start, busy            | item_i   (dvru_in_t)
// result    | done_o (one cycle)     | result_o (dvru_out_t)
// config    | cfg_we_i               | cfg_wdata_i (own node)
//
// A word goes from accept through S_ENTRY to the done_o strobe; the first
// pair of a vector also visits S_COST, reading the sender's entry before
// the destination's entry through the single read port of the route RAM.
// Reset marks all entries unreachable through per-entry valid bits; no
// clearing pass. done_o is shown one cycle and the next word may be
// accepted in that same cycle.
module distance_vector_route_update #(
  parameter int NODE_COUNT = dvru_pkg::NODE_COUNT_DEF,
  parameter int DIST_BITS  = dvru_pkg::DIST_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  dvru_pkg::dvru_in_t               item_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [dvru_pkg::NODE_W-1:0] cfg_wdata_i,
  output logic                             done_o,
  output dvru_pkg::dvru_out_t              result_o
);
  import dvru_pkg::*;

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int ENT_W = DIST_BITS + NODE_W;
  localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};

  typedef enum logic [1:0] {S_IDLE, S_COST, S_ENTRY} state_e;

  function automatic logic [IDX_W-1:0] to_idx(logic [NODE_W-1:0] n);
    return IDX_W'(n);
  endfunction

  state_e              state_q, state_d;
  dvru_in_t            item_q;
  logic [NODE_W-1:0]   own_node_q;
  logic [DIST_BITS-1:0] cost_q;
  logic                vec_open_q;
  logic                acc_q;
  logic                done_q;
  dvru_out_t           res_q;
  logic [NODE_COUNT-1:0] ent_vld_q;
  logic                rd_vld_q;

  logic                accept;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [ENT_W-1:0]    rd_data;
  logic                wr_en;
  logic [ENT_W-1:0]    wr_data;
  logic [DIST_BITS-1:0] ent_dist;
  logic [NODE_W-1:0]   ent_hop;
  logic                dest_ok;
  logic                sender_ok;
  logic [DIST_BITS-1:0] old_dist;
  logic [NODE_W-1:0]   old_hop;
  logic [DIST_BITS-1:0] new_dist;
  logic [NODE_W-1:0]   new_hop;
  logic                changed;
  logic                acc_next;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_en = 1'b1;
          if (item_i.func == FUNC_VECTOR && !vec_open_q) begin
            rd_addr = to_idx(item_i.sender);
            state_d = S_COST;
          end else begin
            rd_addr = to_idx(item_i.dest);
            state_d = S_ENTRY;
          end
        end
      end
      S_COST: begin
        rd_en   = 1'b1;
        rd_addr = to_idx(item_q.dest);
        state_d = S_ENTRY;
      end
      S_ENTRY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // entries never written read as unreachable
  assign ent_dist  = rd_vld_q ? rd_data[DIST_BITS-1:0] : INF;
  assign ent_hop   = rd_vld_q ? rd_data[ENT_W-1:DIST_BITS] : '0;
  assign dest_ok   = (32'(item_q.dest) < NODE_COUNT);
  assign sender_ok = (32'(item_q.sender) < NODE_COUNT);
  assign old_dist  = dest_ok ? ent_dist : INF;
  assign old_hop   = dest_ok ? ent_hop : '0;

  dvru_relax #(
    .DIST_BITS(DIST_BITS)
  ) u_relax (
    .item_i    (item_q),
    .own_node_i(own_node_q),
    .cost_i    (cost_q),
    .dest_ok_i (dest_ok),
    .old_dist_i(old_dist),
    .old_hop_i (old_hop),
    .new_dist_o(new_dist),
    .new_hop_o (new_hop),
    .changed_o (changed)
  );

  assign wr_en    = (state_q == S_ENTRY) && dest_ok;
  assign wr_data  = {new_hop, new_dist};
  assign acc_next = acc_q || changed;

  dvru_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NODE_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(to_idx(item_q.dest)),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      item_q     <= '0;
      own_node_q <= '0;
      cost_q     <= '0;
      vec_open_q <= 1'b0;
      acc_q      <= 1'b0;
      done_q     <= 1'b0;
      res_q      <= '0;
      ent_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_we_i) begin
        own_node_q <= cfg_wdata_i;
      end
      if (accept) begin
        item_q <= item_i;
      end
      if (rd_en) begin
        rd_vld_q <= ent_vld_q[rd_addr];
      end
      case (state_q)
        S_COST: begin
          // latch the cost to the sender and open the vector
          cost_q     <= sender_ok ? ent_dist : INF;
          vec_open_q <= 1'b1;
          acc_q      <= 1'b0;
        end
        S_ENTRY: begin
          if (wr_en) begin
            ent_vld_q[to_idx(item_q.dest)] <= 1'b1;
          end
          done_q                 <= 1'b1;
          res_q.out_dest         <= item_q.dest;
          res_q.out_dist         <= DIST_W'(new_dist);
          res_q.out_hop          <= new_hop;
          res_q.entry_changed    <= changed;
          res_q.out_last         <= item_q.last;
          res_q.table_changed    <= 1'b0;
          if (item_q.func == FUNC_VECTOR) begin
            if (item_q.last) begin
              res_q.table_changed <= acc_next;
              vec_open_q          <= 1'b0;
              acc_q               <= 1'b0;
            end else begin
              acc_q <= acc_next;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

/* tb/sv/dvru_route_checker.sv */
`timescale 1ns / 1ps
module dvru_route_checker
  import dvru_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  dvru_in_t          item_i,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_wdata_i,
  input  logic              done_i,
  input  dvru_out_t         result_i,
  output int                outstanding_o,
  output int                fail_count_o
);

  localparam int                NODES    = 1 << NODE_W;
  localparam logic [DIST_W-1:0] DIST_INF = '1;
  localparam logic [DIST_W-1:0] DIST_CAP = DIST_INF - 1'b1;

  logic [DIST_W-1:0] dist_tab [NODES];
  logic [NODE_W-1:0] hop_tab [NODES];
  logic [DIST_W-1:0] latched_cost;
  logic              vector_open;
  logic              changes_seen;
  logic [NODE_W-1:0] own_id;

  dvru_out_t expected_routes [$];
  dvru_out_t want;
  int        words_in;
  int        words_out;
  int        mismatches;

  assign outstanding_o = words_in - words_out;
  assign fail_count_o  = mismatches;

  // Apply one word to the shadow table and return the route it reports.
  function automatic dvru_out_t route_step(dvru_in_t w);
    logic [DIST_W-1:0] was_dist;
    logic [DIST_W-1:0] now_dist;
    logic [DIST_W-1:0] sum;
    logic [DIST_W:0]   wide;
    logic [NODE_W-1:0] was_hop;
    logic [NODE_W-1:0] now_hop;
    logic              moved;
    dvru_out_t         res;
    was_dist = dist_tab[w.dest];
    was_hop  = hop_tab[w.dest];
    now_dist = was_dist;
    now_hop  = was_hop;
    res      = '0;
    if (w.func == FUNC_LOAD) begin
      now_dist = w.dist_req;
      now_hop  = w.hop;
    end else begin
      // latch the cost to the sender on the first pair only
      if (!vector_open) begin
        latched_cost = dist_tab[w.sender];
        vector_open  = 1'b1;
        changes_seen = 1'b0;
      end
      if (w.dest != own_id) begin
        if (w.dist_req == DIST_INF || latched_cost == DIST_INF) begin
          sum = DIST_INF;
        end else begin
          wide = {1'b0, w.dist_req} + {1'b0, latched_cost};
          sum  = (wide > {1'b0, DIST_CAP}) ? DIST_CAP : wide[DIST_W-1:0];
        end
        if (now_hop == w.sender && now_dist != sum) now_dist = sum;
        if (w.dist_req != DIST_INF && sum != DIST_INF && sum < now_dist) begin
          now_dist = sum;
          now_hop  = w.sender;
        end
      end
    end
    moved             = (now_dist != was_dist) || (now_hop != was_hop);
    dist_tab[w.dest]  = now_dist;
    hop_tab[w.dest]   = now_hop;
    if (w.func == FUNC_VECTOR) begin
      if (moved) changes_seen = 1'b1;
      if (w.last) begin
        res.table_changed = changes_seen;
        vector_open       = 1'b0;
        changes_seen      = 1'b0;
      end
    end
    res.out_dest      = w.dest;
    res.out_dist      = now_dist;
    res.out_hop       = now_hop;
    res.entry_changed = moved;
    res.out_last      = w.last;
    return res;
  endfunction

  task automatic report_field(string field, logic [31:0] exp_val, logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        dist_tab[i] = DIST_INF;
        hop_tab[i]  = '0;
      end
      latched_cost = '0;
      vector_open  = 1'b0;
      changes_seen = 1'b0;
      own_id       = '0;
      expected_routes.delete();
      words_in   <= 0;
      words_out  <= 0;
      mismatches = 0;
    end else begin
      if (done_i) begin
        if (expected_routes.size() == 0) begin
          $display("%0t: route word with none expected, actual %p", $time, result_i);
          mismatches++;
        end else begin
          want = expected_routes.pop_front();
          words_out <= words_out + 1;
          report_field("out_dest", 32'(want.out_dest), 32'(result_i.out_dest));
          report_field("out_dist", 32'(want.out_dist), 32'(result_i.out_dist));
          report_field("out_hop", 32'(want.out_hop), 32'(result_i.out_hop));
          report_field("entry_changed", 32'(want.entry_changed),
                       32'(result_i.entry_changed));
          report_field("table_changed", 32'(want.table_changed),
                       32'(result_i.table_changed));
          report_field("out_last", 32'(want.out_last), 32'(result_i.out_last));
        end
      end
      if (start_i && !busy_i) begin
        expected_routes.push_back(route_step(item_i));
        words_in <= words_in + 1;
      end
      if (cfg_we_i) own_id = cfg_wdata_i;
    end
  end

endmodule

/* tb/sv/tb_distance_vector_route_update.sv */
`timescale 1ns / 1ps
module tb_distance_vector_route_update;
  import dvru_pkg::*;

  localparam int                IDLE_LIMIT = 500;
  localparam logic [DIST_W-1:0] DIST_INF   = '1;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  dvru_in_t          item;
  logic              cfg_we_i;
  logic [NODE_W-1:0] cfg_wdata_i;
  logic              done_o;
  dvru_out_t         result;

  int outstanding;
  int fail_count;
  int idle_cycles = 0;
  int burst_left  = 0;

  distance_vector_route_update i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result)
  );

  dvru_route_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .item_i        (item),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_i        (done_o),
    .result_i      (result),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic dvru_in_t word(logic f, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                                    logic [DIST_W-1:0] dist_val, logic [NODE_W-1:0] nh,
                                    logic lst);
    dvru_in_t w;
    w.func     = f;
    w.sender   = src;
    w.dest     = dst;
    w.dist_req = dist_val;
    w.hop      = nh;
    w.last     = lst;
    return w;
  endfunction

  function automatic logic [DIST_W-1:0] rand_dist();
    case ($urandom_range(0, 9))
      0:       return DIST_INF;
      1:       return DIST_INF - 1'b1;
      2:       return DIST_W'($urandom_range(65000, 65535));
      3, 4:    return DIST_W'($urandom);
      default: return DIST_W'($urandom_range(0, 200));
    endcase
  endfunction

  function automatic dvru_in_t random_load();
    return word(FUNC_LOAD, NODE_W'($urandom), NODE_W'($urandom), rand_dist(),
                NODE_W'($urandom), 1'($urandom_range(0, 1)));
  endfunction

  // Idle the sender between bursts; some bursts run long with no gap.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    burst_left--;
  endtask

  task automatic send_word(dvru_in_t w);
    pace();
    start <= 1'b1;
    item  <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic drain_words();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic set_own_node(logic [NODE_W-1:0] node);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= node;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed vectors, with stray loads, sender swaps and unclosed vectors.
  task automatic run_random_phase(int n);
    int                sent;
    int                pairs;
    logic [NODE_W-1:0] src;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(random_load());
        sent++;
      end else begin
        src   = NODE_W'($urandom);
        pairs = $urandom_range(1, 6);
        for (int k = 0; k < pairs; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            send_word(random_load());
            sent++;
          end
          if ($urandom_range(0, 24) == 0) src = NODE_W'($urandom);
          send_word(word(FUNC_VECTOR, src, NODE_W'($urandom), rand_dist(), NODE_W'($urandom),
                         (k == pairs - 1) && ($urandom_range(0, 19) != 0)));
          sent++;
        end
      end
      if ($urandom_range(0, 149) == 0) drain_words();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item        <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_own_node(3'd5);

    // Directed words, own node 5.
    send_word(word(FUNC_LOAD,   3'd0, 3'd1, 16'd10,     3'd1, 1'b0));
    send_word(word(FUNC_LOAD,   3'd0, 3'd2, DIST_INF,   3'd2, 1'b0));
    send_word(word(FUNC_LOAD,   3'd0, 3'd4, 16'd100,    3'd1, 1'b0));
    send_word(word(FUNC_LOAD,   3'd0, 3'd0, 16'd0,      3'd0, 1'b0));
    // reroute through the current hop, skip own node, ignore far INF, saturate
    send_word(word(FUNC_VECTOR, 3'd1, 3'd4, 16'd50,     3'd0, 1'b0));
    send_word(word(FUNC_VECTOR, 3'd1, 3'd5, 16'd0,      3'd0, 1'b0));
    send_word(word(FUNC_VECTOR, 3'd1, 3'd6, DIST_INF,   3'd0, 1'b0));
    send_word(word(FUNC_VECTOR, 3'd1, 3'd3, 16'd65534,  3'd0, 1'b0));
    send_word(word(FUNC_VECTOR, 3'd1, 3'd0, 16'd0,      3'd0, 1'b1));
    // unreachable sender
    send_word(word(FUNC_VECTOR, 3'd2, 3'd6, 16'd0,      3'd7, 1'b1));
    // INF through the current hop, then a load inside an open vector
    send_word(word(FUNC_VECTOR, 3'd1, 3'd4, DIST_INF,   3'd0, 1'b0));
    send_word(word(FUNC_LOAD,   3'd0, 3'd1, 16'd3,      3'd0, 1'b0));
    send_word(word(FUNC_VECTOR, 3'd1, 3'd7, 16'd5,      3'd0, 1'b1));
    send_word(word(FUNC_VECTOR, 3'd7, 3'd7, DIST_INF,   3'd7, 1'b1));
    send_word(word(FUNC_LOAD,   3'd7, 3'd7, DIST_INF,   3'd7, 1'b1));
    send_word(word(FUNC_VECTOR, 3'd0, 3'd3, DIST_INF,   3'd0, 1'b0));
    send_word(word(FUNC_VECTOR, 3'd0, 3'd2, DIST_INF,   3'd0, 1'b1));
    send_word(word(FUNC_LOAD,   3'd0, 3'd6, 16'd65534,  3'd7, 1'b0));
    send_word(word(FUNC_VECTOR, 3'd6, 3'd1, 16'd1,      3'd0, 1'b1));
    send_word(word(FUNC_VECTOR, 3'd0, 3'd6, 16'd65533,  3'd0, 1'b1));
    send_word(word(FUNC_VECTOR, 3'd5, 3'd2, 16'd0,      3'd0, 1'b1));
    send_word(word(FUNC_VECTOR, 3'd0, 3'd5, 16'hAAAA,   3'd5, 1'b1));

    for (int p = 0; p < 6; p++) begin
      drain_words();
      case (p)
        0:       set_own_node('0);
        1:       set_own_node('1);
        default: set_own_node(NODE_W'($urandom));
      endcase
      run_random_phase(185);
    end

    drain_words();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
